### hw/rtl/ltfh_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ltfh_pkg
// Shared constants, codes and types of the lock table with FIFO hand-off.
// ---------------------------------------------------------------------------
package ltfh_pkg;

	// parameter defaults
	localparam int NUM_LOCKS_DEF   = 64;
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int CLIENT_BITS_DEF = 10;

	// port field widths
	localparam int CMD_W  = 3;
	localparam int IDX_W  = 6;
	localparam int CLI_W  = 10;
	localparam int STAT_W = 2;

	// commands
	localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ACQUIRE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STAT_W-1:0] ST_QUEUED = 2'd1;
	localparam logic [STAT_W-1:0] ST_FAILED = 2'd2;

	// result item kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_NOTE   = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [STAT_W-1:0] status;
		logic [CLI_W-1:0]  client;
		logic              granted;
	} item_t;

endpackage
`default_nettype wire

### hw/rtl/ltfh_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ltfh_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ltfh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### hw/rtl/lock_table_fifo_handoff_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lock_table_fifo_handoff_top
// Lock table with per-entry FIFO wait queue. A small sequencer walks one
// wait slot per cycle for release, cancel and remove, unless out_stall holds it.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | in        | in_valid / in_stall | command, lock_index, client_id,
//          |           |                     | notify_cancel
//  out     | out       | out_valid/out_stall | item_kind, status,
//          |           |                     | notified_client, granted, last
//
//  Create, acquire and any command that fails decode pass through accept,
//  decode and finish. Release, cancel and remove that pass decode also walk
//  up to QUEUE_DEPTH waiting slots, one per cycle unless out_stall holds it,
//  through the wait-slot RAM read port; a granting release stops at the
//  granted slot.
//  One command at a time; in_stall is high from accept until the final item.
//  out_stall holds the sequencer only when an item is ready to leave.
//  Reset clears the exists and owned flags at once; no clearing pass.
// ---------------------------------------------------------------------------
module lock_table_fifo_handoff_top #(
	parameter int NUM_LOCKS   = ltfh_pkg::NUM_LOCKS_DEF,
	parameter int QUEUE_DEPTH = ltfh_pkg::QUEUE_DEPTH_DEF,
	parameter int CLIENT_BITS = ltfh_pkg::CLIENT_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [ltfh_pkg::CMD_W-1:0]  command,
	input  wire logic [ltfh_pkg::IDX_W-1:0]  lock_index,
	input  wire logic [ltfh_pkg::CLI_W-1:0]  client_id,
	input  wire logic                        notify_cancel,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             item_kind,
	output logic [ltfh_pkg::STAT_W-1:0]      status,
	output logic [ltfh_pkg::CLI_W-1:0]       notified_client,
	output logic                             granted,
	output logic                             last
);

	import ltfh_pkg::*;

	// only 2^IDX_W entries can be addressed
	localparam int NUM_ENT = (NUM_LOCKS < (1 << IDX_W)) ? NUM_LOCKS : (1 << IDX_W);
	localparam int LW      = (NUM_ENT > 1) ? $clog2(NUM_ENT) : 1;
	localparam int PW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW      = $clog2(QUEUE_DEPTH + 1);
	localparam int CB      = CLIENT_BITS;
	localparam int EW      = CB + PW + CW;
	localparam int SW      = CB + 1;
	localparam int SDEPTH  = NUM_ENT << PW;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DEC  = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]       state_q;
	logic [CMD_W-1:0] cmd_q;
	logic [LW-1:0]    ent_q;
	logic [CB-1:0]    cli_q;
	logic             notify_q;
	logic             inrange_q;
	logic             act_q;
	logic             own_q;
	logic [CB-1:0]    owner_q;
	logic [PW-1:0]    pos_q;
	logic [CW-1:0]    rem_q;
	item_t            pend_q;

	logic             exists_q [NUM_ENT];
	logic             owned_q  [NUM_ENT];

	item_t            out_q;
	logic             out_last_q;
	logic             out_valid_q;

	// entry RAM: {owner, head, count}
	logic             ent_we;
	logic [EW-1:0]    ent_wdata;
	logic [LW-1:0]    ent_raddr;
	logic [EW-1:0]    ent_rdata;
	logic [CB-1:0]    owner_rd;
	logic [PW-1:0]    head_rd;
	logic [CW-1:0]    cnt_rd;

	// wait-slot RAM: {live, client}
	logic             slot_we;
	logic [LW+PW-1:0] slot_waddr;
	logic [SW-1:0]    slot_wdata;
	logic [LW+PW-1:0] slot_raddr;
	logic [SW-1:0]    slot_rdata;
	logic             slot_live;
	logic [CB-1:0]    slot_cli;

	logic             out_free;
	logic             push;
	logic             push_last;
	item_t            push_item;
	logic             advance;
	logic [PW-1:0]    pos_next;
	logic [PW:0]      tail_sum;
	logic [PW-1:0]    tail;
	logic             ok;
	logic             owned_now;
	logic             cancel_hit;

	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign owner_rd  = ent_rdata[EW-1 -: CB];
	assign head_rd   = ent_rdata[CW +: PW];
	assign cnt_rd    = ent_rdata[CW-1:0];
	assign slot_live = slot_rdata[CB];
	assign slot_cli  = slot_rdata[CB-1:0];
	assign ok        = inrange_q && exists_q[ent_q];
	assign owned_now = owned_q[ent_q];
	assign pos_next  = (pos_q == PW'(QUEUE_DEPTH - 1)) ? '0 : pos_q + PW'(1);
	assign tail_sum  = (PW+1)'(head_rd) + (PW+1)'(cnt_rd);
	assign tail      = (tail_sum >= (PW+1)'(QUEUE_DEPTH)) ?
		PW'(tail_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);
	assign cancel_hit = slot_live && (slot_cli == cli_q);

	assign ent_raddr  = (state_q == S_IDLE) ? LW'(lock_index) : ent_q;
	assign ent_wdata  = {owner_q, (cmd_q == CMD_REMOVE) ? PW'(0) : pos_q, rem_q};
	assign slot_waddr = {ent_q, (state_q == S_DEC) ? tail : pos_q};
	assign slot_wdata = (state_q == S_DEC) ? {1'b1, cli_q} : '0;

	always_comb begin
		push      = 1'b0;
		push_last = 1'b0;
		push_item = pend_q;
		advance   = 1'b0;
		slot_we   = 1'b0;
		ent_we    = 1'b0;
		slot_raddr = {ent_q, pos_q};
		case (state_q)
			S_DEC: begin
				slot_raddr = {ent_q, head_rd};
				if (cmd_q == CMD_ACQUIRE && ok && owned_now && owner_rd != cli_q &&
				    cnt_rd < CW'(QUEUE_DEPTH)) begin
					slot_we = 1'b1;
				end
			end
			S_WALK: begin
				if (rem_q != '0) begin
					case (cmd_q)
						CMD_RELEASE, CMD_REMOVE: begin
							if (!slot_live) begin
								advance = 1'b1;
							end else if (out_free) begin
								advance = 1'b1;
								push    = 1'b1;
							end
						end
						CMD_CANCEL: begin
							if (!cancel_hit || !notify_q) begin
								advance = 1'b1;
								slot_we = cancel_hit;
							end else if (out_free) begin
								advance = 1'b1;
								slot_we = 1'b1;
								push    = 1'b1;
								// first hit turns the held status item into a success
								if (pend_q.kind == KIND_STATUS) begin
									push_item.status = ST_DONE;
								end
							end
						end
						default: begin
							advance = 1'b1;
						end
					endcase
				end
				if (advance) begin
					slot_raddr = {ent_q, pos_next};
				end
			end
			S_DONE: begin
				ent_we = act_q && (cmd_q != CMD_CANCEL);
				if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	ltfh_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_ENT)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_q),
		.wdata(ent_wdata),
		.raddr(ent_raddr),
		.rdata(ent_rdata)
	);

	ltfh_ram #(
		.WIDTH(SW),
		.DEPTH(SDEPTH)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.raddr(slot_raddr),
		.rdata(slot_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q      <= push_item;
			out_last_q <= push_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign item_kind       = out_q.kind;
	assign status          = out_q.status;
	assign notified_client = out_q.client;
	assign granted         = out_q.granted;
	assign last            = out_last_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < NUM_ENT; i++) begin
				exists_q[i] <= 1'b0;
				owned_q[i]  <= 1'b0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					case (cmd_q)
						CMD_RELEASE, CMD_REMOVE: begin
							state_q <= (ok && owned_now && owner_rd == cli_q) ? S_WALK : S_DONE;
						end
						CMD_CANCEL: begin
							state_q <= ok ? S_WALK : S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_WALK: begin
					if (rem_q == '0 || (cmd_q == CMD_RELEASE && push)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (act_q) begin
							case (cmd_q)
								CMD_CREATE: begin
									exists_q[ent_q] <= 1'b1;
									owned_q[ent_q]  <= 1'b0;
								end
								CMD_ACQUIRE: begin
									owned_q[ent_q] <= 1'b1;
								end
								CMD_RELEASE: begin
									owned_q[ent_q] <= own_q;
								end
								CMD_REMOVE: begin
									exists_q[ent_q] <= 1'b0;
									owned_q[ent_q]  <= 1'b0;
								end
								default: begin
								end
							endcase
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q     <= command;
				ent_q     <= LW'(lock_index);
				cli_q     <= CB'(client_id);
				notify_q  <= notify_cancel;
				inrange_q <= (32'(lock_index) < NUM_LOCKS);
			end
			S_DEC: begin
				act_q   <= 1'b0;
				own_q   <= 1'b0;
				owner_q <= owner_rd;
				pos_q   <= head_rd;
				rem_q   <= cnt_rd;
				pend_q  <= '{kind: KIND_STATUS, status: ST_FAILED, client: '0, granted: 1'b0};
				case (cmd_q)
					CMD_CREATE: begin
						if (inrange_q && !ok) begin
							act_q         <= 1'b1;
							pos_q         <= '0;
							rem_q         <= '0;
							pend_q.status <= ST_DONE;
						end
					end
					CMD_ACQUIRE: begin
						if (ok) begin
							if (!owned_now) begin
								act_q         <= 1'b1;
								owner_q       <= cli_q;
								pend_q.status <= ST_DONE;
							end else if (owner_rd == cli_q) begin
								pend_q.status <= ST_DONE;
							end else if (cnt_rd < CW'(QUEUE_DEPTH)) begin
								act_q         <= 1'b1;
								rem_q         <= cnt_rd + CW'(1);
								pend_q.status <= ST_QUEUED;
							end
						end
					end
					CMD_RELEASE, CMD_REMOVE: begin
						if (ok && owned_now && owner_rd == cli_q) begin
							act_q         <= 1'b1;
							pend_q.status <= ST_DONE;
						end
					end
					default: begin
					end
				endcase
			end
			S_WALK: begin
				if (advance) begin
					pos_q <= pos_next;
					rem_q <= rem_q - CW'(1);
				end
				if (push) begin
					case (cmd_q)
						CMD_RELEASE: begin
							own_q   <= 1'b1;
							owner_q <= slot_cli;
							pend_q  <= '{kind: KIND_NOTE, status: ST_DONE,
								client: CLI_W'(slot_cli), granted: 1'b1};
						end
						CMD_REMOVE: begin
							pend_q <= '{kind: KIND_NOTE, status: ST_FAILED,
								client: CLI_W'(slot_cli), granted: 1'b0};
						end
						default: begin
							pend_q <= '{kind: KIND_NOTE, status: ST_FAILED,
								client: CLI_W'(cli_q), granted: 1'b0};
						end
					endcase
				end else if (cmd_q == CMD_CANCEL && advance && cancel_hit) begin
					// quiet cancel: no notices, only the status changes
					pend_q.status <= ST_DONE;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_DEC)
		else $error("accepted transfer did not reach decode");

	a_grant_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == KIND_NOTE && granted |-> status == ST_DONE)
		else $error("grant notice with non-done status");

	a_owned_exists: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DEC && inrange_q |-> !owned_q[ent_q] || exists_q[ent_q])
		else $error("owned flag set on a missing entry");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> rem_q <= CW'(QUEUE_DEPTH))
		else $error("walk count beyond queue depth");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_free |=> out_valid && last && state_q == S_IDLE)
		else $error("final transfer not marked last");
`endif

endmodule
`default_nettype wire

### tb/lock_table_fifo_handoff_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lock_table_fifo_handoff_top_tb
// Drives create, acquire, release, cancel and remove commands into the lock
// table, keeps a mirror of every entry and its wait queue, and checks each
// result item against the items the mirror predicts for that command. The
// sender works in bursts, the receiver stalls on a pattern of its own, and a
// long receiver hold-off backs the block up into its input.
// ---------------------------------------------------------------------------
module lock_table_fifo_handoff_top_tb;
	import ltfh_pkg::*;

	localparam int LOCKS  = NUM_LOCKS_DEF;
	localparam int QDEPTH = QUEUE_DEPTH_DEF;
	localparam int LIVE   = CLI_W;	// live mark sits above the client id
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic              kind;
		logic [STAT_W-1:0] status;
		logic [CLI_W-1:0]  client;
		logic              granted;
		logic              last;
	} result_t;

	typedef enum {RX_OPEN, RX_COIN, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	// mirror of the lock table; queues up the items each command produces
	class lock_table_mirror;
		bit               present [LOCKS];
		bit               held    [LOCKS];
		logic [CLI_W-1:0] holder  [LOCKS];
		logic [CLI_W:0]   slot    [LOCKS][QDEPTH];
		int unsigned      head    [LOCKS];
		int unsigned      fill    [LOCKS];
		result_t          awaited [$];
		int               errors;

		function new();
			int e, q;
			for (e = 0; e < LOCKS; e++) begin
				present[e] = 1'b0;
				held[e]    = 1'b0;
				holder[e]  = '0;
				head[e]    = 0;
				fill[e]    = 0;
				for (q = 0; q < QDEPTH; q++)
					slot[e][q] = '0;
			end
			errors = 0;
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
				logic [CLI_W-1:0] cli, logic nfy);
			logic [STAT_W-1:0] st;
			logic [CLI_W:0]    s;
			result_t           items [$];
			int unsigned       k, pos;
			bit                walking;
			st = ST_FAILED;
			case (cmd)
			CMD_CREATE: begin
				if (!present[idx]) begin
					present[idx] = 1'b1;
					held[idx]    = 1'b0;
					head[idx]    = 0;
					fill[idx]    = 0;
					st = ST_DONE;
				end
			end
			CMD_ACQUIRE: begin
				if (present[idx]) begin
					if (!held[idx]) begin
						held[idx]   = 1'b1;
						holder[idx] = cli;
						st = ST_DONE;
					end else if (holder[idx] == cli) begin
						st = ST_DONE;
					end else if (fill[idx] < QDEPTH) begin
						slot[idx][(head[idx] + fill[idx]) % QDEPTH] = {1'b1, cli};
						fill[idx]++;
						st = ST_QUEUED;
					end
				end
			end
			CMD_RELEASE: begin
				if (present[idx] && held[idx] && holder[idx] == cli) begin
					held[idx] = 1'b0;
					walking = 1'b1;
					// hand over to the oldest live waiter, dropping blanked slots
					while (walking && fill[idx] != 0) begin
						s = slot[idx][head[idx]];
						head[idx] = (head[idx] + 1) % QDEPTH;
						fill[idx]--;
						if (s[LIVE]) begin
							held[idx]   = 1'b1;
							holder[idx] = s[CLI_W-1:0];
							items.push_back('{KIND_NOTE, ST_DONE, s[CLI_W-1:0], 1'b1, 1'b0});
							walking = 1'b0;
						end
					end
					st = ST_DONE;
				end
			end
			CMD_CANCEL: begin
				if (present[idx]) begin
					for (k = 0; k < fill[idx]; k++) begin
						pos = (head[idx] + k) % QDEPTH;
						s = slot[idx][pos];
						if (s[LIVE] && s[CLI_W-1:0] == cli) begin
							slot[idx][pos] = '0;
							st = ST_DONE;
							if (nfy)
								items.push_back('{KIND_NOTE, ST_FAILED, cli, 1'b0, 1'b0});
						end
					end
				end
			end
			CMD_REMOVE: begin
				if (present[idx] && held[idx] && holder[idx] == cli) begin
					while (fill[idx] != 0) begin
						s = slot[idx][head[idx]];
						head[idx] = (head[idx] + 1) % QDEPTH;
						fill[idx]--;
						if (s[LIVE])
							items.push_back('{KIND_NOTE, ST_FAILED, s[CLI_W-1:0], 1'b0, 1'b0});
					end
					present[idx] = 1'b0;
					held[idx]    = 1'b0;
					head[idx]    = 0;
					st = ST_DONE;
				end
			end
			default: ;
			endcase
			items.push_front('{KIND_STATUS, st, '0, 1'b0, 1'b0});
			items[items.size() - 1].last = 1'b1;
			foreach (items[n])
				awaited.push_back(items[n]);
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s got %0d, expected %0d", name, got, want));
		endtask

		task check_item(logic kind, logic [STAT_W-1:0] st, logic [CLI_W-1:0] cl,
				logic gr, logic lst);
			result_t want;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected item kind=%0d status=%0d client=%0d granted=%0d last=%0d",
					kind, st, cl, gr, lst));
			end else begin
				want = awaited.pop_front();
				compare_field("item_kind", 32'(kind), 32'(want.kind));
				compare_field("status", 32'(st), 32'(want.status));
				compare_field("notified_client", 32'(cl), 32'(want.client));
				compare_field("granted", 32'(gr), 32'(want.granted));
				compare_field("last", 32'(lst), 32'(want.last));
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic [CMD_W-1:0]  command = '0;
	logic [IDX_W-1:0]  lock_index = '0;
	logic [CLI_W-1:0]  client_id = '0;
	logic              notify_cancel = 1'b0;
	logic              out_stall = 1'b0;
	logic              in_stall;
	logic              out_valid;
	logic              item_kind;
	logic [STAT_W-1:0] status;
	logic [CLI_W-1:0]  notified_client;
	logic              granted;
	logic              last;

	lock_table_mirror mirror;
	int               burst_left = 0;
	bit               hold_request = 1'b0;

	lock_table_fifo_handoff_top DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.lock_index      (lock_index),
		.client_id       (client_id),
		.notify_cancel   (notify_cancel),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.item_kind       (item_kind),
		.status          (status),
		.notified_client (notified_client),
		.granted         (granted),
		.last            (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// one command per call; valid stays up across a burst
	task automatic send_cmd(logic [CMD_W-1:0] c, logic [IDX_W-1:0] i,
			logic [CLI_W-1:0] k, logic n);
		command       <= c;
		lock_index    <= i;
		client_id     <= k;
		notify_cancel <= n;
		in_valid      <= 1'b1;
		do @(posedge clk); while (in_stall);
		mirror.note_command(c, i, k, n);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(20, 60)) @(posedge clk);
			else
				repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
				: $urandom_range(0, 6);
		end
	endtask

	// receiver: stall pattern changes mode now and then; long hold on request
	initial begin
		rx_mode_t    mode;
		int unsigned mode_left, phase, held_cycles;
		mode = RX_OPEN;
		mode_left = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				for (held_cycles = 0; held_cycles < HOLD_CYCLES; held_cycles++)
					@(posedge clk);
				hold_request = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				phase++;
				case (mode)
				RX_OPEN:     out_stall <= 1'b0;
				RX_COIN:     out_stall <= 1'($urandom_range(0, 1));
				RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
				RX_PERIODIC: out_stall <= (phase % 3 == 0);
				endcase
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				mirror.check_item(item_kind, status, notified_client, granted, last);
		end
	end

	initial begin
		logic [IDX_W-1:0] hot [4];
		logic [CLI_W-1:0] crowd [5];
		logic [CMD_W-1:0] c;
		logic [IDX_W-1:0] i;
		logic [CLI_W-1:0] k, boss;
		logic [CLI_W-1:0] ca, cb, cc;
		int unsigned      n, r, waited;

		mirror = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: missing entry, bad commands, queueing, cancel, hand-off
		ca = '0;
		cb = '1;
		cc = 10'h155;
		i  = '1;
		send_cmd(CMD_ACQUIRE, i, ca, 1'b0);
		send_cmd(CMD_RELEASE, i, ca, 1'b0);
		send_cmd(CMD_REMOVE,  i, ca, 1'b0);
		send_cmd(CMD_CANCEL,  i, ca, 1'b1);
		send_cmd(CMD_CREATE,  i, ca, 1'b0);
		send_cmd(CMD_CREATE,  i, cb, 1'b0);
		for (n = int'(CMD_REMOVE) + 1; n < (1 << CMD_W); n++)
			send_cmd(n[CMD_W-1:0], '0, cc, n[0]);
		send_cmd(CMD_RELEASE, i, ca, 1'b0);	// unowned
		send_cmd(CMD_ACQUIRE, i, ca, 1'b0);
		send_cmd(CMD_ACQUIRE, i, ca, 1'b0);	// re-grant to owner
		send_cmd(CMD_ACQUIRE, i, cb, 1'b0);
		send_cmd(CMD_ACQUIRE, i, cc, 1'b0);
		send_cmd(CMD_ACQUIRE, i, cb, 1'b0);	// same client twice in queue
		send_cmd(CMD_CANCEL,  i, cb, 1'b1);
		send_cmd(CMD_CANCEL,  i, cb, 1'b1);	// nothing left to blank
		send_cmd(CMD_RELEASE, i, cc, 1'b0);	// non-owner
		send_cmd(CMD_REMOVE,  i, cc, 1'b0);	// non-owner
		send_cmd(CMD_RELEASE, i, ca, 1'b0);	// skips blank slot, grants cc
		send_cmd(CMD_ACQUIRE, i, cb, 1'b0);
		send_cmd(CMD_CANCEL,  i, cb, 1'b0);
		send_cmd(CMD_RELEASE, i, cc, 1'b0);	// only blanks left, lock goes free
		send_cmd(CMD_ACQUIRE, i, ca, 1'b0);
		send_cmd(CMD_ACQUIRE, i, cb, 1'b0);
		send_cmd(CMD_REMOVE,  i, ca, 1'b0);
		send_cmd(CMD_CREATE,  '0, cb, 1'b1);

		foreach (hot[j])
			hot[j] = IDX_W'($urandom_range(0, LOCKS - 1));
		foreach (crowd[j])
			crowd[j] = CLI_W'($urandom_range(0, (1 << CLI_W) - 1));

		// receiver holds off while the queue of one entry is filled past full,
		// then the owner removes it, denying every waiter
		hold_request = 1'b1;
		i = hot[0];
		send_cmd(CMD_CREATE, i, crowd[0], 1'b0);
		boss = mirror.held[i] ? mirror.holder[i] : crowd[0];
		send_cmd(CMD_ACQUIRE, i, boss, 1'b0);
		for (n = 0; n < QDEPTH + 2; n++)
			send_cmd(CMD_ACQUIRE, i, CLI_W'($urandom_range(0, (1 << CLI_W) - 1)),
				1'($urandom_range(0, 1)));
		send_cmd(CMD_REMOVE, i, boss, 1'b0);

		// random traffic on a few hot entries with a small set of clients
		for (n = 0; n < 110; n++) begin
			if (n % 40 == 39)
				foreach (crowd[j])
					crowd[j] = CLI_W'($urandom_range(0, (1 << CLI_W) - 1));
			i = ($urandom_range(0, 6) == 0) ? IDX_W'($urandom_range(0, LOCKS - 1))
				: hot[$urandom_range(0, 3)];
			k = crowd[$urandom_range(0, 4)];
			r = $urandom_range(0, 99);
			if (!mirror.present[i] && r < 75)
				c = CMD_CREATE;
			else if (r < 8)
				c = CMD_CREATE;
			else if (r < 50)
				c = CMD_ACQUIRE;
			else if (r < 70)
				c = CMD_RELEASE;
			else if (r < 85)
				c = CMD_CANCEL;
			else if (r < 96)
				c = CMD_REMOVE;
			else
				c = CMD_W'($urandom_range(int'(CMD_REMOVE) + 1, (1 << CMD_W) - 1));
			if ((c == CMD_RELEASE || c == CMD_REMOVE) && mirror.held[i]
					&& $urandom_range(0, 4) != 0)
				k = mirror.holder[i];
			send_cmd(c, i, k, 1'($urandom_range(0, 1)));
		end
		if (in_valid)
			in_valid <= 1'b0;

		for (waited = 0; mirror.awaited.size() != 0 && waited < 20000; waited++)
			@(posedge clk);
		repeat (3 * QDEPTH) @(posedge clk);
		if (mirror.awaited.size() != 0)
			mirror.report($sformatf("%0d expected items never arrived", mirror.awaited.size()));

		if (mirror.errors == 0)
			$display("PASS lock_table_fifo_handoff_top");
		else
			$display("FAIL lock_table_fifo_handoff_top");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL lock_table_fifo_handoff_top");
		$finish;
	end

endmodule
